>>> rtl/dns_query_redirect_responder_unit_assert.svh
// Assertion macros used by the checker file of the DNS redirect responder.
`ifndef DNS_QUERY_REDIRECT_RESPONDER_UNIT_ASSERT_SVH
`define DNS_QUERY_REDIRECT_RESPONDER_UNIT_ASSERT_SVH

// Clocked property with an active-low reset that disables the check.
`define DQR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication between an antecedent and a consequent.
`define DQR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/dqr_pkg.sv
// Shared types and constants of the DNS redirect responder.
`timescale 1ns / 1ps
`default_nettype none
package dqr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 512;
  localparam int unsigned RECORD_BYTES     = 16;
  localparam int unsigned HEADER_BYTES     = 12;
  localparam int unsigned RESP_LEN_W       = 10;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CFG_DATA_W       = 32;

  localparam logic [31:0] ADDRESS_RESET = 32'hC0A8_0401;
  localparam logic [31:0] TTL_RESET     = 32'h0000_003C;

  localparam logic [7:0]  FLAGS_HI      = 8'h81;
  localparam logic [7:0]  FLAGS_LO      = 8'h80;
  localparam logic [7:0]  NAME_PTR_HI   = 8'hC0;
  localparam logic [7:0]  NAME_PTR_LO   = 8'h0C;
  localparam logic [7:0]  LABEL_PTR_MSK = 8'hC0;
  localparam logic [15:0] QTYPE_A       = 16'd1;
  localparam logic [15:0] QTYPE_ANY     = 16'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANSWER_ADDRESS = 1'b0,
    CFG_ANSWER_TTL     = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_PUSH  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic                  result_kind;
    logic [7:0]            response_byte;
    logic                  response_final;
    logic                  respond;
    logic                  answered;
    logic [RESP_LEN_W-1:0] response_length;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;   // query byte transaction taken this cycle
    logic fetch;  // fetch transaction taken this cycle
    logic emit;   // fetched byte is complete, queue its result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;   // output queue holds two results
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/dqr_ifs.sv
// Channel interfaces of the DNS redirect responder: request, result, configuration.
`timescale 1ns / 1ps
`default_nettype none
interface dqr_req_if;
  logic valid;
  logic ready;
  logic mode;
  logic [7:0] query_byte;
  logic query_last;
  modport source (output valid, mode, query_byte, query_last, input ready);
  modport sink   (input valid, mode, query_byte, query_last, output ready);
endinterface

interface dqr_rsp_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic [7:0] response_byte;
  logic response_final;
  logic respond;
  logic answered;
  logic [dqr_pkg::RESP_LEN_W-1:0] response_length;
  modport source (output valid, result_kind, response_byte, response_final, respond,
                  answered, response_length, input ready);
  modport sink   (input valid, result_kind, response_byte, response_final, respond,
                  answered, response_length, output ready);
endinterface

interface dqr_cfg_if;
  logic valid;
  logic ready;
  logic [dqr_pkg::CFG_IDX_W-1:0] index;
  logic [dqr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/dns_query_redirect_responder_unit.sv
// Top level of the DNS redirect responder: controller, datapath and channel wiring.
//
//   channel  direction  transaction carries
//   -------  ---------  ---------------------------------------------------------
//   req_i    in         mode, query_byte, query_last
//   rsp_o    out        result_kind, response_byte, response_final, respond,
//                       answered, response_length
//   cfg_i    in         index (0 answer_address, 1 answer_ttl), data
//
// On a query byte transaction the RAM write and label walk happen at the accepting
// edge, and the last byte queues the summary in the same cycle.
// A fetch transaction registers the packet-store read and queues its byte in the emit
// state; no transaction is taken meanwhile. Reset clears all control state; the packet
// store is not cleared and needs no sweep. Results wait in a two-entry output queue, so
// a stalled result does not block input until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module dns_query_redirect_responder_unit #(
  parameter int unsigned BUFFER_BYTES = dqr_pkg::BUFFER_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dqr_req_if.sink      req_i,
  dqr_rsp_if.source    rsp_o,
  dqr_cfg_if.sink      cfg_i
);
  import dqr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    out_data;
  logic       out_valid;

  // Configuration writes are always taken; the user writes only while the
  // block is idle, and the registers are sampled when a reply is built.
  assign cfg_i.ready = 1'b1;

  // The controller decides when a transaction is taken and when a fetched
  // byte is ready to be queued.
  dqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_mode_i  (req_i.mode),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the packet store, the question parser, the reply
  // generator and the output queue.
  dqr_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .query_byte_i (req_i.query_byte),
    .query_last_i (req_i.query_last),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (out_valid),
    .out_ready_i  (rsp_o.ready),
    .out_data_o   (out_data)
  );

  assign rsp_o.valid           = out_valid;
  assign rsp_o.result_kind     = out_data.result_kind;
  assign rsp_o.response_byte   = out_data.response_byte;
  assign rsp_o.response_final  = out_data.response_final;
  assign rsp_o.respond         = out_data.respond;
  assign rsp_o.answered        = out_data.answered;
  assign rsp_o.response_length = out_data.response_length;

endmodule
`default_nettype wire

>>> rtl/dqr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dqr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/dqr_ctrl.sv
// Controller of the DNS redirect responder: takes transactions and sequences fetches.
`timescale 1ns / 1ps
`default_nettype none
module dqr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  input  dqr_pkg::dp_status_t status_i,
  output dqr_pkg::dp_cmd_t    cmd_o
);
  import dqr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   take;

  // A transaction is taken only when the output queue has room for its result.
  assign in_ready_o  = (state_q == ST_IDLE) && !status_i.full;
  assign take        = in_valid_i && in_ready_o;
  assign cmd_o.push  = take && (in_mode_i == MODE_PUSH);
  assign cmd_o.fetch = take && (in_mode_i == MODE_FETCH);
  assign cmd_o.emit  = (state_q == ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.fetch) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/dqr_datapath.sv
// Datapath of the DNS redirect responder: packet store, question parser, reply generator, output queue.
`timescale 1ns / 1ps
`default_nettype none
module dqr_datapath #(
  parameter int unsigned BUFFER_BYTES = dqr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dqr_pkg::dp_cmd_t                 cmd_i,
  output dqr_pkg::dp_status_t              status_o,
  input  logic [7:0]                       query_byte_i,
  input  logic                             query_last_i,
  input  logic                             cfg_we_i,
  input  logic [dqr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dqr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output dqr_pkg::result_t                 out_data_o
);
  import dqr_pkg::*;

  localparam int unsigned AW          = $clog2(BUFFER_BYTES);
  localparam int unsigned PW          = AW + 1;
  localparam int unsigned NW          = $clog2(BUFFER_BYTES + 256);
  localparam int unsigned STORE_LIMIT = BUFFER_BYTES - RECORD_BYTES;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LABELS,
    PH_TAIL,
    PH_DONE,
    PH_STOP
  } phase_e;

  function automatic logic [7:0] record_byte(input logic [3:0] k, input logic [31:0] ttl,
                                             input logic [31:0] addr);
    logic [7:0] b;
    case (k)
      4'd0:    b = NAME_PTR_HI;
      4'd1:    b = NAME_PTR_LO;
      4'd3:    b = 8'h01;
      4'd5:    b = 8'h01;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd11:   b = 8'h04;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Query parse state.
  logic [PW-1:0] bytes_q, bytes_n;
  logic [NW-1:0] nla_q, nla_n;
  phase_e        phase_q, phase_n;
  logic [15:0]   qtype_q, qtype_n;
  logic [PW-1:0] qend_q, qend_n;

  // Pending reply state.
  logic [PW-1:0] pos_q, size_q;
  logic          ans_q;
  logic [PW-1:0] rqend_q;
  logic [31:0]   ttl_q, addr_q;
  logic [31:0]   cfg_ttl_q, cfg_addr_q;

  // Fetch byte waiting for the store read.
  logic          sel_store_q;
  logic [7:0]    gen_byte_q;
  logic          gen_final_q;

  // Two-entry output queue.
  result_t       fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  logic [PW-1:0] at;
  logic [NW-1:0] at_ext, rel;
  logic          store_en;
  logic          resp, ans_n;
  logic [PW-1:0] rlen;
  logic          have, fin, sel_store, in_rec;
  logic [PW-1:0] nxt;
  logic [7:0]    gen_byte;
  logic [7:0]    ram_rdata;
  logic          q_push, q_pop;
  result_t       q_entry;

  // Label walk on the byte being pushed.
  assign at       = bytes_q;
  assign at_ext   = NW'(at);
  assign rel      = at_ext - nla_q;
  assign store_en = cmd_i.push && (at < PW'(STORE_LIMIT));

  always_comb begin
    bytes_n = bytes_q;
    nla_n   = nla_q;
    phase_n = phase_q;
    qtype_n = qtype_q;
    qend_n  = qend_q;
    if (at < PW'(STORE_LIMIT)) begin
      bytes_n = at + PW'(1);
      case (phase_q)
        PH_HEADER: begin
          if (at == PW'(HEADER_BYTES - 1)) begin
            phase_n = PH_LABELS;
          end
        end
        PH_LABELS: begin
          if (at_ext == nla_q) begin
            if (query_byte_i == 8'h00) begin
              nla_n   = at_ext + NW'(1);
              phase_n = PH_TAIL;
            end else if ((query_byte_i & LABEL_PTR_MSK) != 8'h00) begin
              phase_n = PH_STOP;
            end else begin
              nla_n = at_ext + NW'(1) + NW'(query_byte_i);
            end
          end
        end
        PH_TAIL: begin
          if (rel == NW'(0)) begin
            qtype_n = {query_byte_i, 8'h00};
          end else if (rel == NW'(1)) begin
            qtype_n = {qtype_q[15:8], query_byte_i};
          end else if (rel == NW'(3)) begin
            qend_n  = at + PW'(1);
            phase_n = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // End-of-query summary, from the state after this byte.
  assign resp  = bytes_n >= PW'(HEADER_BYTES);
  assign ans_n = resp && (phase_n == PH_DONE) && ((qtype_n == QTYPE_A) || (qtype_n == QTYPE_ANY));
  assign rlen  = !resp ? '0 : (ans_n ? qend_n + PW'(RECORD_BYTES) : PW'(HEADER_BYTES));

  // Reply byte at the current read position.
  assign have      = pos_q < size_q;
  assign nxt       = pos_q + PW'(1);
  assign fin       = !have || (nxt == size_q);
  assign in_rec    = ans_q && (pos_q >= rqend_q);
  assign sel_store = have && ((pos_q < PW'(2)) ||
                     (ans_q && (pos_q >= PW'(HEADER_BYTES)) && (pos_q < rqend_q)));

  always_comb begin
    gen_byte = 8'h00;
    if (have) begin
      if (pos_q == PW'(2)) begin
        gen_byte = FLAGS_HI;
      end else if (pos_q == PW'(3)) begin
        gen_byte = FLAGS_LO;
      end else if (pos_q < PW'(HEADER_BYTES)) begin
        // Question and answer counts are one each on an answering reply.
        gen_byte = (ans_q && ((pos_q == PW'(5)) || (pos_q == PW'(7)))) ? 8'h01 : 8'h00;
      end else if (in_rec) begin
        gen_byte = record_byte(4'(pos_q - rqend_q), ttl_q, addr_q);
      end
    end
  end

  dqr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (at[AW-1:0]),
    .wdata_i (query_byte_i),
    .re_i    (cmd_i.fetch),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q    <= '0;
      nla_q      <= NW'(HEADER_BYTES);
      phase_q    <= PH_HEADER;
      qtype_q    <= '0;
      qend_q     <= '0;
      pos_q      <= '0;
      size_q     <= '0;
      ans_q      <= 1'b0;
      cfg_addr_q <= ADDRESS_RESET;
      cfg_ttl_q  <= TTL_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_ANSWER_ADDRESS: cfg_addr_q <= cfg_data_i;
          CFG_ANSWER_TTL:     cfg_ttl_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.push) begin
        pos_q <= '0;
        if (query_last_i) begin
          size_q  <= rlen;
          ans_q   <= ans_n;
          bytes_q <= '0;
          nla_q   <= NW'(HEADER_BYTES);
          phase_q <= PH_HEADER;
          qtype_q <= '0;
          qend_q  <= '0;
        end else begin
          size_q  <= '0;
          bytes_q <= bytes_n;
          nla_q   <= nla_n;
          phase_q <= phase_n;
          qtype_q <= qtype_n;
          qend_q  <= qend_n;
        end
      end else if (cmd_i.fetch && have) begin
        if (nxt == size_q) begin
          pos_q  <= '0;
          size_q <= '0;
        end else begin
          pos_q <= nxt;
        end
      end
    end
  end

  // Reply payload latched at the end of a query; config sampled there.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && query_last_i) begin
      rqend_q <= qend_n;
      ttl_q   <= cfg_ttl_q;
      addr_q  <= cfg_addr_q;
    end
    if (cmd_i.fetch) begin
      sel_store_q <= sel_store;
      gen_byte_q  <= gen_byte;
      gen_final_q <= fin;
    end
  end

  // Output queue.
  assign q_push = (cmd_i.push && query_last_i) || cmd_i.emit;
  assign q_pop  = out_valid_o && out_ready_i;

  always_comb begin
    q_entry = '0;
    if (cmd_i.emit) begin
      q_entry.result_kind    = KIND_BYTE;
      q_entry.response_byte  = sel_store_q ? ram_rdata : gen_byte_q;
      q_entry.response_final = gen_final_q;
    end else begin
      q_entry.result_kind     = KIND_SUMMARY;
      q_entry.respond         = resp;
      q_entry.answered        = ans_n;
      q_entry.response_length = RESP_LEN_W'(rlen);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      fifo_q[wr_ptr_q] <= q_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (q_push && !q_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (q_pop && !q_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign out_data_o    = fifo_q[rd_ptr_q];
  assign status_o.full = (cnt_q == 2'd2);

endmodule
`default_nettype wire

>>> rtl/dqr_checker.sv
// Port-level checker of the DNS redirect responder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "dns_query_redirect_responder_unit_assert.svh"
module dqr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic                               result_kind_i,
  input logic [7:0]                         response_byte_i,
  input logic                               response_final_i,
  input logic                               respond_i,
  input logic                               answered_i,
  input logic [dqr_pkg::RESP_LEN_W-1:0]     response_length_i
);
  import dqr_pkg::*;

  // Smallest answering reply: header, a root name, type and class, one record.
  localparam logic [RESP_LEN_W-1:0] MIN_ANSWER_LEN =
    RESP_LEN_W'(HEADER_BYTES + 1 + 4 + RECORD_BYTES);

  logic summary, byte_res;
  assign summary  = rsp_valid_i && (result_kind_i == KIND_SUMMARY);
  assign byte_res = rsp_valid_i && (result_kind_i == KIND_BYTE);

  `DQR_ASSERT(a_rsp_hold, clk_i, rst_ni,
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(result_kind_i) &&
      $stable(response_byte_i) && $stable(response_final_i) && $stable(response_length_i)),
    "stalled result changed")
  `DQR_ASSERT_IMPLIES(a_summary_clean, clk_i, rst_ni, summary,
    (response_byte_i == 8'h00) && !response_final_i, "summary carries byte fields")
  `DQR_ASSERT_IMPLIES(a_byte_clean, clk_i, rst_ni, byte_res,
    !respond_i && !answered_i && (response_length_i == '0), "byte result carries summary")
  `DQR_ASSERT_IMPLIES(a_no_reply, clk_i, rst_ni, summary && !respond_i,
    !answered_i && (response_length_i == '0), "silent summary has a length")
  `DQR_ASSERT_IMPLIES(a_answer_len, clk_i, rst_ni, summary && answered_i,
    respond_i && (response_length_i >= MIN_ANSWER_LEN), "answer reply too short")

endmodule

bind dns_query_redirect_responder_unit dqr_checker u_dqr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .result_kind_i     (rsp_o.result_kind),
  .response_byte_i   (rsp_o.response_byte),
  .response_final_i  (rsp_o.response_final),
  .respond_i         (rsp_o.respond),
  .answered_i        (rsp_o.answered),
  .response_length_i (rsp_o.response_length)
);
`default_nettype wire
